### rtl/rpn_pkg.sv
// rpn_pkg: shared types and codes for the rpn stack calculator
// command/response payload structs, action and status codes, controller states
// no dependencies
package rpn_pkg;

	localparam int DEFAULT_STACK_DEPTH = 16;

	// iterative multiply and divide step counts
	localparam int MUL_STEPS = 32;
	localparam int DIV_STEPS = 48;
	localparam int STEP_CW   = $clog2(DIV_STEPS);

	// action codes
	localparam logic [2:0] ACT_PUSH = 3'd0;
	localparam logic [2:0] ACT_PEEK = 3'd1;
	localparam logic [2:0] ACT_ADD  = 3'd2;
	localparam logic [2:0] ACT_SUB  = 3'd3;
	localparam logic [2:0] ACT_MUL  = 3'd4;
	localparam logic [2:0] ACT_DIV  = 3'd5;
	localparam logic [2:0] ACT_SWAP = 3'd6;

	// status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_EMPTY = 3'd1;
	localparam logic [2:0] ST_ONE   = 3'd2;
	localparam logic [2:0] ST_FULL  = 3'd3;
	localparam logic [2:0] ST_DIV0  = 3'd4;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] operand_value;
	} rpn_cmd_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] top_value;
		logic               top_valid;
		logic [4:0]         stack_depth;
	} rpn_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_OPER,
		S_MUL,
		S_DIV,
		S_FIN,
		S_SWAP2,
		S_RESP
	} rpn_state_t;

endpackage

### rtl/rpn_stack_calculator.sv
// rpn_stack_calculator: postfix calculator on a bounded stack of Q16.16 values
// stack entries in a synchronous memory, shared iterative multiply/divide unit
// depends on rpn_pkg
module rpn_stack_calculator
	import rpn_pkg::*;
#(
	parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	input  rpn_cmd_t cmd,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output rpn_rsp_t rsp
);

	// One command is taken per transaction and gives exactly one response
	// transaction carrying the status, the new top of stack and the depth.
	// Commands are handled one at a time. Push, peek, unused codes and
	// underflow cases go to the response state; add and subtract pass through
	// the operate state, exchange through a second write state (two writes
	// through the single memory write port), multiply through 32 shift-add
	// steps and divide through 48 restoring steps (one quotient bit per cycle)
	// of the shared iterative unit. The second operand comes from the stack
	// memory through a registered read; the top entry is also kept in a
	// register so it never needs a read. The response sits in its own register,
	// so a new command is accepted while the previous response still waits.
	// STACK_DEPTH may range from 2 to 1024; the reported depth is its low
	// five bits. The memory needs no clearing: only written entries are read.

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	// stack memory
	logic [31:0] mem [STACK_DEPTH];
	logic [31:0] rd_data_q;
	logic        mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0] mem_wdata;

	// control state
	rpn_state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic          cnt_inc, cnt_dec;
	logic          rsp_load;
	logic          rsp_valid_q;
	rpn_rsp_t      rsp_q;

	// datapath registers
	logic [2:0]         op_q;
	logic [2:0]         stat_q;
	logic [31:0]        top_q;
	logic [31:0]        a_q;
	logic [63:0]        mag_q;
	logic [31:0]        rem_q;
	logic               neg_q;
	logic [STEP_CW-1:0] step_q;

	// derived
	logic [CW-1:0] cm1, cm2;
	logic          accept;
	logic          is_binop;
	logic          full, has_two;
	logic [31:0]   p_mag, q_mag;
	logic [32:0]   sum33, dif33;
	logic [31:0]   addsub_res;
	logic [32:0]   mul_sum;
	logic [32:0]   div_shift;
	logic          div_ge;
	logic [47:0]   fin_mag;
	logic [31:0]   sat_res;
	logic          slot_free;

	assign cm1      = count_q - CW'(1);
	assign cm2      = count_q - CW'(2);
	assign accept   = cmd_valid && cmd_ready;
	assign is_binop = cmd.action inside {ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_SWAP};
	assign full     = (count_q == CW'(STACK_DEPTH));
	assign has_two  = (count_q >= CW'(2));
	assign slot_free = !rsp_valid_q || rsp_ready;

	// operands: p is the cached top, q the entry below it read from memory
	assign p_mag = top_q[31] ? 32'(-top_q) : top_q;
	assign q_mag = rd_data_q[31] ? 32'(-rd_data_q) : rd_data_q;

	// add and subtract with saturation on 33-bit result
	assign sum33 = {rd_data_q[31], rd_data_q} + {top_q[31], top_q};
	assign dif33 = {rd_data_q[31], rd_data_q} - {top_q[31], top_q};
	always_comb begin
		logic [32:0] r;
		r = (op_q == ACT_SUB) ? dif33 : sum33;
		if (r[32] != r[31]) begin
			addsub_res = r[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			addsub_res = r[31:0];
		end
	end

	// one shift-add multiply step: add multiplicand into upper half, shift right
	assign mul_sum = {1'b0, mag_q[63:32]} + (mag_q[0] ? {1'b0, a_q} : 33'd0);

	// one restoring divide step
	assign div_shift = {rem_q, mag_q[47]};
	assign div_ge    = (div_shift >= {1'b0, a_q});

	// magnitude after truncation toward zero, then sign and saturate
	assign fin_mag = (op_q == ACT_MUL) ? mag_q[63:16] : mag_q[47:0];
	always_comb begin
		if (!neg_q) begin
			sat_res = (fin_mag > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : fin_mag[31:0];
		end else begin
			sat_res = (fin_mag > 48'h0000_8000_0000) ? 32'h8000_0000 : 32'(-fin_mag[31:0]);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					state_d = (is_binop && has_two) ? S_OPER : S_RESP;
				end
			end
			S_OPER: begin
				unique case (op_q)
					ACT_MUL:  state_d = S_MUL;
					ACT_DIV:  state_d = (top_q == 32'd0) ? S_RESP : S_DIV;
					ACT_SWAP: state_d = S_SWAP2;
					default:  state_d = S_RESP;
				endcase
			end
			S_MUL, S_DIV: begin
				if (step_q == '0) begin
					state_d = S_FIN;
				end
			end
			S_FIN:   state_d = S_RESP;
			S_SWAP2: state_d = S_RESP;
			S_RESP: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// controller outputs
	always_comb begin
		cmd_ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cm2[AW-1:0];
		mem_wdata = top_q;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid && cmd.action == ACT_PUSH && !full) begin
					mem_we    = 1'b1;
					mem_waddr = count_q[AW-1:0];
					mem_wdata = cmd.operand_value;
					cnt_inc   = 1'b1;
				end
			end
			S_OPER: begin
				if (op_q == ACT_ADD || op_q == ACT_SUB) begin
					mem_we    = 1'b1;
					mem_wdata = addsub_res;
					cnt_dec   = 1'b1;
				end else if (op_q == ACT_SWAP) begin
					// old top goes below
					mem_we = 1'b1;
				end
			end
			S_FIN: begin
				mem_we    = 1'b1;
				mem_wdata = sat_res;
				cnt_dec   = 1'b1;
			end
			S_SWAP2: begin
				// old second entry, now cached as top, goes on top
				mem_we    = 1'b1;
				mem_waddr = cm1[AW-1:0];
			end
			S_RESP: begin
				rsp_load = slot_free;
			end
			default: ;
		endcase
	end

	// memory: one write port, one registered read of the entry below the top
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[cm2[AW-1:0]];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q <= cmd.action;
					if (cmd.action == ACT_PUSH && full) begin
						stat_q <= ST_FULL;
					end else if ((cmd.action == ACT_PEEK || is_binop) && count_q == '0) begin
						stat_q <= ST_EMPTY;
					end else if (is_binop && !has_two) begin
						stat_q <= ST_ONE;
					end else begin
						stat_q <= ST_OK;
					end
					if (cmd.action == ACT_PUSH && !full) begin
						top_q <= cmd.operand_value;
					end
				end
			end
			S_OPER: begin
				neg_q <= top_q[31] ^ rd_data_q[31];
				case (op_q)
					ACT_MUL: begin
						a_q    <= q_mag;
						mag_q  <= {32'd0, p_mag};
						step_q <= STEP_CW'(MUL_STEPS - 1);
					end
					ACT_DIV: begin
						if (top_q == 32'd0) begin
							stat_q <= ST_DIV0;
						end
						a_q    <= p_mag;
						mag_q  <= {16'd0, q_mag, 16'd0};
						rem_q  <= '0;
						step_q <= STEP_CW'(DIV_STEPS - 1);
					end
					ACT_SWAP: top_q <= rd_data_q;
					default:  top_q <= addsub_res;
				endcase
			end
			S_MUL: begin
				mag_q  <= {mul_sum, mag_q[31:1]};
				step_q <= step_q - STEP_CW'(1);
			end
			S_DIV: begin
				rem_q  <= div_ge ? 32'(div_shift - {1'b0, a_q}) : div_shift[31:0];
				mag_q  <= {16'd0, mag_q[46:0], div_ge};
				step_q <= step_q - STEP_CW'(1);
			end
			S_FIN: begin
				top_q <= sat_res;
			end
			default: ;
		endcase
	end

	// response register
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.status      <= stat_q;
			rsp_q.top_valid   <= (count_q != '0);
			rsp_q.top_value   <= (count_q != '0) ? top_q : 32'd0;
			rsp_q.stack_depth <= 5'(count_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
